/* rtl/ostb_pkg.sv */
`timescale 1ns / 1ps
// ostb_pkg: constants, codes and shared types of the one-shot timer bank
// no dependencies

package ostb_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [8:0]  ID_LIMIT      = 9'(SLOT_COUNT);
  localparam logic [15:0] MAX_SLEEP_RST = 16'd200;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_REFRESH = 3'd1,
    OP_STOP    = 3'd2,
    OP_QUERY   = 3'd3,
    OP_TICK    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_REPLY   = 2'd0,
    KIND_EVENT   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_SCAN,
    ST_SUMMARY
  } state_t;

  // verdict of the shared slot comparator
  typedef struct packed {
    logic        expired;
    logic        closer;
    logic [15:0] rem_lo;
  } eval_t;

endpackage

/* rtl/ostb_if.sv */
`timescale 1ns / 1ps
// ostb_in_if, ostb_out_if, ostb_cfg_if: valid/ready channels of the timer bank
// no dependencies

interface ostb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  timer_id;
  logic [30:0] delay_ms;
  logic        has_handler;
  logic [15:0] elapsed_ms;

  modport source (output valid, opcode, timer_id, delay_ms, has_handler, elapsed_ms,
                  input ready);
  modport sink   (input valid, opcode, timer_id, delay_ms, has_handler, elapsed_ms,
                  output ready);
endinterface

interface ostb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  slot;
  logic        status;
  logic        is_active;
  logic [15:0] next_wake_ms;
  logic        last;

  modport source (output valid, kind, slot, status, is_active, next_wake_ms, last,
                  input ready);
  modport sink   (input valid, kind, slot, status, is_active, next_wake_ms, last,
                  output ready);
endinterface

interface ostb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_sleep_ms;

  modport source (output valid, max_sleep_ms, input ready);
  modport sink   (input valid, max_sleep_ms, output ready);
endinterface

/* rtl/ostb_slot_eval.sv */
`timescale 1ns / 1ps
// ostb_slot_eval: shared subtract and compare unit used once per slot in a scan
// depends on ostb_pkg

module ostb_slot_eval (
  input  logic [31:0]     deadline,
  input  logic [31:0]     now,
  input  logic [15:0]     wake,
  output ostb_pkg::eval_t verdict
);
  import ostb_pkg::*;

  logic [31:0] rem;

  // wrapping distance to the deadline
  assign rem = deadline - now;

  always_comb begin
    verdict.expired = (rem == 32'd0) || rem[31];
    verdict.closer  = (rem[31:16] == 16'd0) && (rem[15:0] < wake);
    verdict.rem_lo  = rem[15:0];
  end

endmodule

/* rtl/one_shot_timer_bank_top.sv */
`timescale 1ns / 1ps
// one_shot_timer_bank_top: bank of one-shot millisecond timers with a scan sequencer
// depends on ostb_pkg, ostb_if (ostb_in_if, ostb_out_if, ostb_cfg_if), ostb_slot_eval
//
//   channel   dir  beat carries                                          ready when
//   in_ch     in   opcode, timer_id, delay_ms, has_handler, elapsed_ms    sequencer idle
//   out_ch    out  kind, slot, status, is_active, next_wake_ms, last      -
//   cfg_ch    in   max_sleep_ms                                          always
//
// a command is accepted, then its reply goes into the output register once that register is free
// a tick scans one slot a cycle through the shared comparator, then the summary;
// each expiry event needs a free output register, so a stalled sink holds the scan
// on that slot
// reset (rst_n low, synchronous) disarms all slots, clears time, restores max sleep 200
// the output register frees in the cycle its beat is taken, so no bubble is lost

module one_shot_timer_bank_top (
  input logic     clk,
  input logic     rst_n,
  ostb_in_if.sink   in_ch,
  ostb_out_if.source out_ch,
  ostb_cfg_if.sink  cfg_ch
);
  import ostb_pkg::*;

  // control state
  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [SLOT_COUNT-1:0] armed_r, armed_nxt;
  logic [SLOT_COUNT-1:0] handler_r, handler_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [15:0]         max_sleep_r;
  logic [15:0]         wake_r, wake_nxt;

  // deadline store, its value only used while its slot is armed
  logic [31:0]         deadline_r [SLOT_COUNT];
  logic                dl_we;
  logic [SLOT_W-1:0]   dl_waddr;
  logic [31:0]         dl_wdata;
  logic [31:0]         dl_rdata_r;

  // pending command reply
  logic [7:0]          rep_slot_r, rep_slot_nxt;
  logic                rep_status_r, rep_status_nxt;
  logic                rep_active_r, rep_active_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [7:0]          out_slot_r, out_slot_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_active_r, out_active_nxt;
  logic [15:0]         out_wake_r, out_wake_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_acc;
  logic                out_free;
  logic                id_ok;
  logic [SLOT_W-1:0]   cmd_idx;
  opcode_t             op;
  eval_t               verdict;
  logic                fire;
  logic                scan_stall;
  logic                scan_end;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign id_ok        = ({1'b0, in_ch.timer_id} < ID_LIMIT);
  assign cmd_idx      = in_ch.timer_id[SLOT_W-1:0];
  assign op           = opcode_t'(in_ch.opcode);

  // one slot per cycle through the shared comparator, unless a stalled sink holds the scan
  ostb_slot_eval u_eval (
    .deadline (dl_rdata_r),
    .now      (now_r),
    .wake     (wake_r),
    .verdict  (verdict)
  );

  assign fire       = armed_r[idx_r] && verdict.expired && handler_r[idx_r];
  assign scan_stall = fire && !out_free;
  assign scan_end   = (idx_r == SLOT_W'(SLOT_COUNT - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (op == OP_TICK) ? ST_SCAN : ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_stall && scan_end) begin
          state_nxt = ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register control
  always_comb begin
    idx_nxt        = idx_r;
    armed_nxt      = armed_r;
    handler_nxt    = handler_r;
    now_nxt        = now_r;
    wake_nxt       = wake_r;
    dl_we          = 1'b0;
    dl_waddr       = cmd_idx;
    dl_wdata       = now_r + {1'b0, in_ch.delay_ms};
    rep_slot_nxt   = rep_slot_r;
    rep_status_nxt = rep_status_r;
    rep_active_nxt = rep_active_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_active_nxt = out_active_r;
    out_wake_nxt   = out_wake_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rep_slot_nxt   = in_ch.timer_id;
          rep_status_nxt = 1'b0;
          rep_active_nxt = 1'b0;
          if (op == OP_TICK) begin
            now_nxt  = now_r + 32'(in_ch.elapsed_ms);
            wake_nxt = max_sleep_r;
            idx_nxt  = '0;
          end else if (!id_ok) begin
            rep_status_nxt = 1'b1;
          end else begin
            case (op)
              OP_SET: begin
                dl_we                = 1'b1;
                armed_nxt[cmd_idx]   = 1'b1;
                handler_nxt[cmd_idx] = in_ch.has_handler;
              end
              OP_REFRESH: begin
                // idle slot without handler refuses the rearm
                if (!armed_r[cmd_idx] && !handler_r[cmd_idx]) begin
                  rep_status_nxt = 1'b1;
                end else begin
                  dl_we              = 1'b1;
                  armed_nxt[cmd_idx] = 1'b1;
                end
              end
              OP_STOP: begin
                armed_nxt[cmd_idx] = 1'b0;
              end
              OP_QUERY: begin
                rep_active_nxt = armed_r[cmd_idx];
              end
              default: begin
                rep_status_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_REPLY;
          out_slot_nxt   = rep_slot_r;
          out_status_nxt = rep_status_r;
          out_active_nxt = rep_active_r;
          out_wake_nxt   = 16'd0;
          out_last_nxt   = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!scan_stall) begin
          if (armed_r[idx_r]) begin
            if (verdict.expired) begin
              armed_nxt[idx_r] = 1'b0;
            end else if (verdict.closer) begin
              wake_nxt = verdict.rem_lo;
            end
          end
          if (fire) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_EVENT;
            out_slot_nxt   = 8'(idx_r);
            out_status_nxt = 1'b0;
            out_active_nxt = 1'b0;
            out_wake_nxt   = 16'd0;
            out_last_nxt   = 1'b0;
          end
          if (!scan_end) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_SUMMARY;
          out_slot_nxt   = 8'd0;
          out_status_nxt = 1'b0;
          out_active_nxt = 1'b0;
          out_wake_nxt   = wake_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      armed_r     <= '0;
      handler_r   <= '0;
      now_r       <= 32'd0;
      max_sleep_r <= MAX_SLEEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      armed_r     <= armed_nxt;
      handler_r   <= handler_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_sleep_r <= cfg_ch.max_sleep_ms;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wake_r       <= wake_nxt;
    rep_slot_r   <= rep_slot_nxt;
    rep_status_r <= rep_status_nxt;
    rep_active_r <= rep_active_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_active_r <= out_active_nxt;
    out_wake_r   <= out_wake_nxt;
    out_last_r   <= out_last_nxt;
  end

  // deadline store; registered read addressed one step ahead, so the comparator
  // always sees the slot under idx_r (no writes happen during a scan)
  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_r[dl_waddr] <= dl_wdata;
    end
    dl_rdata_r <= deadline_r[idx_nxt];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.is_active    = out_active_r;
  assign out_ch.next_wake_ms = out_wake_r;
  assign out_ch.last         = out_last_r;

  // a tick always starts its scan at the first slot
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_TICK) |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("tick did not start scan at slot zero");

  // an expired slot is disarmed once the scan moves past it
  a_expired_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !scan_stall && armed_r[idx_r] && verdict.expired)
    |=> !armed_r[$past(idx_r)])
    else $error("expired slot still armed after scan step");

  // expiry events never close a tick's burst
  a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_EVENT) |-> !out_last_r)
    else $error("expiry event flagged as last beat");

endmodule

/* bench/tb_one_shot_timer_bank_top.sv */
`timescale 1ns / 1ps
// tb_one_shot_timer_bank_top: self-checking bench for the one-shot timer bank
// needs ostb_pkg, ostb_if (ostb_in_if, ostb_out_if, ostb_cfg_if) and one_shot_timer_bank_top

module tb_one_shot_timer_bank_top;
  import ostb_pkg::*;

  // opcodes outside the defined set, all answered with a rejection
  localparam logic [2:0]  OP_FIRST_BAD = 3'd5;
  localparam logic [2:0]  OP_LAST_BAD  = 3'd7;
  localparam logic [30:0] TIMEOUT_MAX  = '1;
  localparam logic [15:0] ELAPSED_MAX  = '1;
  localparam logic [7:0]  ID_MAX       = '1;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PRINT_LIMIT    = 20;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  timer_id;
    logic [30:0] delay_ms;
    logic        has_handler;
    logic [15:0] elapsed_ms;
  } timer_cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slot;
    logic        status;
    logic        is_active;
    logic [15:0] next_wake_ms;
    logic        last;
  } timer_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ostb_in_if  in_ch ();
  ostb_out_if out_ch ();
  ostb_cfg_if cfg_ch ();

  one_shot_timer_bank_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // commands waiting for the driver, and beats the bank still owes us
  timer_cmd_t  pending_cmds[$];
  timer_beat_t expected_beats[$];

  int cmds_issued = 0;
  int cmds_accepted = 0;
  int beats_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // percentages for the current phase
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // shadow of the bank: millisecond clock, per-slot deadline and flags, sleep cap
  logic [31:0] shadow_now;
  logic [31:0] shadow_deadline [SLOT_COUNT];
  logic        shadow_armed    [SLOT_COUNT];
  logic        shadow_handler  [SLOT_COUNT];
  logic [15:0] shadow_sleep_cap;

  // ---------------------------------------------------------------------------
  // shadow model: works out the beats one accepted command should produce
  // ---------------------------------------------------------------------------

  function automatic timer_beat_t make_beat(kind_t kind, logic [7:0] slot, logic status,
                                            logic is_active, logic [15:0] wake, logic last);
    timer_beat_t b;
    b.kind = kind;
    b.slot = slot;
    b.status = status;
    b.is_active = is_active;
    b.next_wake_ms = wake;
    b.last = last;
    return b;
  endfunction

  task automatic expect_timer_beats(input timer_cmd_t c);
    logic [31:0] remaining;
    logic [15:0] wake;
    logic        id_ok;
    int          s;
    id_ok = (c.timer_id < SLOT_COUNT);
    if (c.opcode == OP_TICK) begin
      // advance time, then one pass over the slots in index order
      shadow_now += 32'(c.elapsed_ms);
      wake = shadow_sleep_cap;
      for (s = 0; s < SLOT_COUNT; s++) begin
        if (shadow_armed[s]) begin
          remaining = shadow_deadline[s] - shadow_now;
          // zero or negative distance means the deadline has passed
          if (remaining == 32'd0 || remaining[31]) begin
            shadow_armed[s] = 1'b0;
            if (shadow_handler[s])
              expected_beats.push_back(make_beat(KIND_EVENT, 8'(s), 1'b0, 1'b0, '0, 1'b0));
          end else if (remaining < {16'd0, wake}) begin
            wake = remaining[15:0];
          end
        end
      end
      expected_beats.push_back(make_beat(KIND_SUMMARY, '0, 1'b0, 1'b0, wake, 1'b1));
    end else if (c.opcode > OP_TICK || !id_ok) begin
      // unknown opcode or slot out of range: rejected, nothing changes
      expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b1, 1'b0, '0, 1'b1));
    end else begin
      case (opcode_t'(c.opcode))
        OP_SET: begin
          shadow_deadline[c.timer_id] = shadow_now + 32'(c.delay_ms);
          shadow_armed[c.timer_id] = 1'b1;
          shadow_handler[c.timer_id] = c.has_handler;
          expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b0, 1'b0, '0, 1'b1));
        end
        OP_REFRESH: begin
          // idle slot without a handler cannot be rearmed; handler flag is kept
          if (!shadow_armed[c.timer_id] && !shadow_handler[c.timer_id]) begin
            expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b1, 1'b0, '0, 1'b1));
          end else begin
            shadow_deadline[c.timer_id] = shadow_now + 32'(c.delay_ms);
            shadow_armed[c.timer_id] = 1'b1;
            expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b0, 1'b0, '0, 1'b1));
          end
        end
        OP_STOP: begin
          shadow_armed[c.timer_id] = 1'b0;
          expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b0, 1'b0, '0, 1'b1));
        end
        default: begin
          expected_beats.push_back(make_beat(KIND_REPLY, c.timer_id, 1'b0,
                                             shadow_armed[c.timer_id], '0, 1'b1));
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: result beat %0d, %s: got %0d, expected %0d",
               $realtime, beats_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // command driver: pops the queue, holds the beat until it is taken
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.timer_id = '0;
    in_ch.delay_ms = '0;
    in_ch.has_handler = 1'b0;
    in_ch.elapsed_ms = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_sleep_ms = '0;
  end

  always @(posedge clk) begin : drive_cmds
    timer_cmd_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // slot is free: either send the next command or leave a gap
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        c = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.opcode <= c.opcode;
        in_ch.timer_id <= c.timer_id;
        in_ch.delay_ms <= c.delay_ms;
        in_ch.has_handler <= c.has_handler;
        in_ch.elapsed_ms <= c.elapsed_ms;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: config and command beats feed the shadow, result beats are checked
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_bank
    timer_cmd_t  c;
    timer_beat_t want;
    if (!rst_n) begin
      shadow_now = '0;
      shadow_sleep_cap = MAX_SLEEP_RST;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        shadow_deadline[s] = '0;
        shadow_armed[s] = 1'b0;
        shadow_handler[s] = 1'b0;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        shadow_sleep_cap = cfg_ch.max_sleep_ms;
      // command beats are predicted first; their results cannot leave on this edge
      if (in_ch.valid && in_ch.ready) begin
        c.opcode = in_ch.opcode;
        c.timer_id = in_ch.timer_id;
        c.delay_ms = in_ch.delay_ms;
        c.has_handler = in_ch.has_handler;
        c.elapsed_ms = in_ch.elapsed_ms;
        expect_timer_beats(c);
        cmds_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing outstanding, kind", out_ch.kind, -1);
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.slot !== want.slot)
            report_mismatch("slot", out_ch.slot, want.slot);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
          if (out_ch.is_active !== want.is_active)
            report_mismatch("is_active", out_ch.is_active, want.is_active);
          if (out_ch.next_wake_ms !== want.next_wake_ms)
            report_mismatch("next_wake_ms", out_ch.next_wake_ms, want.next_wake_ms);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
    end
  end

  // watchdog: too long with no beat on any channel means the bank has hung
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no beat accepted", idle_cycles);
      $display("one_shot_timer_bank_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic timer_cmd_t mk_cmd(logic [2:0] op, logic [7:0] id, logic [30:0] tmo,
                                        logic hnd, logic [15:0] el);
    timer_cmd_t c;
    c.opcode = op;
    c.timer_id = id;
    c.delay_ms = tmo;
    c.has_handler = hnd;
    c.elapsed_ms = el;
    return c;
  endfunction

  task automatic queue_cmd(input timer_cmd_t c);
    pending_cmds.push_back(c);
    cmds_issued++;
  endtask

  // mostly short timeouts so ticks catch them, now and then zero, huge or the maximum
  function automatic logic [30:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 31'($urandom_range(0, 400));
    if (r < 80) return '0;
    if (r < 95) return 31'($urandom);
    return TIMEOUT_MAX;
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 16'($urandom_range(1, 150));
    if (r < 85) return '0;
    return 16'($urandom);
  endfunction

  // one random command; fields a command ignores still carry random bits
  task automatic queue_random_cmd();
    timer_cmd_t c;
    int r;
    c = mk_cmd(3'($urandom), 8'($urandom), 31'($urandom), 1'($urandom), 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 30)      c.opcode = OP_SET;
    else if (r < 42) c.opcode = OP_REFRESH;
    else if (r < 50) c.opcode = OP_STOP;
    else if (r < 62) c.opcode = OP_QUERY;
    else if (r < 96) c.opcode = OP_TICK;
    else             c.opcode = 3'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));
    if ($urandom_range(0, 99) < 92)
      c.timer_id = 8'($urandom_range(0, SLOT_COUNT - 1));
    c.delay_ms = pick_timeout();
    c.has_handler = ($urandom_range(0, 3) != 0);
    c.elapsed_ms = pick_elapsed();
    queue_cmd(c);
  endtask

  // arm a batch of slots with short deadlines, then one tick that expires most of them
  task automatic queue_expiry_burst(output int n);
    logic full;
    full = ($urandom_range(0, 2) == 0);
    n = 0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (full || $urandom_range(0, 1) == 1) begin
        queue_cmd(mk_cmd(OP_SET, 8'(s), 31'($urandom_range(0, 60)),
                         full | 1'($urandom_range(0, 3) != 0), 16'($urandom)));
        n++;
      end
    end
    queue_cmd(mk_cmd(OP_TICK, 8'($urandom), 31'($urandom), 1'($urandom),
                     16'($urandom_range(30, 90))));
    n++;
  endtask

  task automatic queue_random_phase(input int n_items);
    int done_items;
    int burst_items;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_expiry_burst(burst_items);
        done_items += burst_items;
      end else begin
        queue_random_cmd();
        done_items++;
      end
    end
  endtask

  // every command taken and every owed beat seen, then a short settle
  task automatic wait_bank_idle();
    do @(posedge clk);
    while (cmds_accepted != cmds_issued || expected_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // sleep cap is only touched while the bank has nothing in flight
  task automatic write_sleep_cap(input logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_sleep_ms <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] cap, input int idle_pct, input int stall_pct,
                           input int n_items);
    write_sleep_cap(cap);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    queue_random_phase(n_items);
    wait_bank_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset sleep cap of 200, no idling
    queue_cmd(mk_cmd(OP_QUERY, 8'd0, '0, 1'b0, '0));              // idle slot reads inactive
    queue_cmd(mk_cmd(OP_REFRESH, 8'd1, 31'd50, 1'b0, '0));        // idle, no handler: refused
    queue_cmd(mk_cmd(OP_SET, 8'd0, '0, 1'b1, '0));                // zero timeout
    queue_cmd(mk_cmd(OP_SET, 8'd15, 31'd5, 1'b0, '0));            // last slot, no handler
    queue_cmd(mk_cmd(OP_SET, 8'd3, TIMEOUT_MAX, 1'b1, ELAPSED_MAX));
    queue_cmd(mk_cmd(OP_SET, 8'(SLOT_COUNT), 31'd7, 1'b1, '0));   // first bad id
    queue_cmd(mk_cmd(OP_QUERY, ID_MAX, '0, 1'b0, '0));            // highest bad id
    queue_cmd(mk_cmd(OP_STOP, ID_MAX, '0, 1'b0, '0));
    queue_cmd(mk_cmd(OP_REFRESH, 8'(SLOT_COUNT), 31'd9, 1'b0, '0));
    queue_cmd(mk_cmd(OP_FIRST_BAD, 8'd2, '0, 1'b0, '0));          // unknown opcodes
    queue_cmd(mk_cmd(OP_LAST_BAD, ID_MAX, TIMEOUT_MAX, 1'b1, ELAPSED_MAX));
    queue_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, '0));                 // zero-timeout slot fires
    queue_cmd(mk_cmd(OP_QUERY, 8'd15, '0, 1'b0, '0));             // still armed
    queue_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, ELAPSED_MAX));        // slot 15 expires silently
    queue_cmd(mk_cmd(OP_QUERY, 8'd15, '0, 1'b0, '0));
    queue_cmd(mk_cmd(OP_REFRESH, 8'd15, 31'd20, 1'b0, '0));       // refused again
    queue_cmd(mk_cmd(OP_REFRESH, 8'd0, 31'd10, 1'b0, '0));        // idle with handler: rearmed
    queue_cmd(mk_cmd(OP_STOP, 8'd3, '0, 1'b0, '0));
    queue_cmd(mk_cmd(OP_STOP, 8'd4, '0, 1'b0, '0));               // stop on an idle slot
    queue_cmd(mk_cmd(OP_REFRESH, 8'd3, 31'd150, 1'b1, '0));       // stopped slot keeps handler
    queue_cmd(mk_cmd(OP_SET, 8'd7, 31'd250, 1'b1, '0));
    queue_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, 16'd10));             // slot 0 fires, nearest deadline wins
    queue_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, 16'd100));            // nearest deadline wins
    queue_cmd(mk_cmd(OP_TICK, '0, '0, 1'b0, 16'd200));            // both expire in one pass
    wait_bank_idle();

    // random phases, each setting its sleep cap and idling pattern
    run_phase(16'hFFFF, 0, 0, 82);
    run_phase(16'd1, 88, 0, 82);
    run_phase(16'd0, 0, 88, 82);
    run_phase(16'($urandom_range(20, 400)), 38, 38, 82);
    run_phase(16'($urandom_range(1, 65535)), 0, 0, 82);

    // allow any stray beat to show up before judging
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("one_shot_timer_bank_top regression: pass");
    end else begin
      $display("one_shot_timer_bank_top regression: fail");
    end
    $finish;
  end

endmodule
